FILE: rtl/core/lpdt_pkg.sv
// Shared types and constants for the LED pulse-distance transmitter.
// No dependencies; imported by led_pulse_distance_transmitter.
package lpdt_pkg;

    // FIFO depth default and field widths
    localparam int LpdtFifoDepth = 16;
    localparam int LpdtByteW     = 8;
    localparam int LpdtCfgIdxW   = 2;

    // Register reset values
    localparam logic [LpdtByteW-1:0] LpdtBankLowReset  = 8'b0111_0000;
    localparam logic [LpdtByteW-1:0] LpdtBankMidReset  = 8'h00;
    localparam logic [LpdtByteW-1:0] LpdtBankHighReset = 8'h00;

    // Bit pointer start (MSB first)
    localparam logic [3:0] LpdtBitStart = 4'd7;

    // Configuration register indexes
    typedef enum logic [LpdtCfgIdxW-1:0] {
        CFG_BANK_LOW  = 2'd0,
        CFG_BANK_MID  = 2'd1,
        CFG_BANK_HIGH = 2'd2
    } lpdt_cfg_idx_t;

    // Request operation codes
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_PUSH = 1'b1
    } lpdt_op_t;

    // Transmit phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2,
        PH_LOW  = 2'd3
    } lpdt_phase_t;

    // One result
    typedef struct packed {
        logic                 leds_written;
        logic [LpdtByteW-1:0] bank_low_out;
        logic [LpdtByteW-1:0] bank_mid_out;
        logic [LpdtByteW-1:0] bank_high_out;
        logic                 receiver_enable_written;
        logic                 receiver_enable_value;
        logic                 receiver_reset_pulse;
        logic                 byte_dropped;
        logic [1:0]           tx_phase;
    } lpdt_result_t;

endpackage

FILE: rtl/core/led_pulse_distance_transmitter.sv
// LED pulse-distance transmitter: top level with FIFO memory, phase machine
// and two-entry output buffer. Depends on lpdt_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries operation and data_byte. A push
//   queues data_byte in the FIFO (flagged as dropped when full); a tick
//   advances the pulse machine by one step. Every request yields exactly one
//   result on the output channel (out_valid/out_stall).
//   Configuration writes (cfg_valid/cfg_ready, always ready) set the three
//   LED bank patterns; index 3 is ignored.
// Registering and throughput:
//   Results are registered (output or skid register). One request is taken
//   per cycle unless in_stall. FIFO head is prefetched from the synchronous
//   memory each cycle with write forwarding; loads never wait on the read port.
// Reset:
//   Phase idle, FIFO empty, bit pointer at seven, patterns at their defaults.
//   FIFO contents are not cleared; entries are only read after being written.
// Stalls:
//   A stalled result holds in the output register while one further result
//   is caught in the skid register; in_stall rises only once that is full.
module led_pulse_distance_transmitter #(
    parameter int FIFO_DEPTH = lpdt_pkg::LpdtFifoDepth
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [lpdt_pkg::LpdtByteW-1:0]      data_byte,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lpdt_pkg::LpdtCfgIdxW-1:0]    cfg_index,
    input  logic [lpdt_pkg::LpdtByteW-1:0]      cfg_data,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                leds_written,
    output logic [lpdt_pkg::LpdtByteW-1:0]      bank_low_out,
    output logic [lpdt_pkg::LpdtByteW-1:0]      bank_mid_out,
    output logic [lpdt_pkg::LpdtByteW-1:0]      bank_high_out,
    output logic                                receiver_enable_written,
    output logic                                receiver_enable_value,
    output logic                                receiver_reset_pulse,
    output logic                                byte_dropped,
    output logic [1:0]                          tx_phase
);
    import lpdt_pkg::*;

    localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CntW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(FIFO_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(FIFO_DEPTH);

    // Configuration registers
    logic [LpdtByteW-1:0] bank_low_reg, bank_mid_reg, bank_high_reg;

    // Control state
    lpdt_phase_t          phase_reg, phase_next;
    logic [LpdtByteW-1:0] shift_reg, shift_next;
    logic [3:0]           bitptr_reg, bitptr_next;
    logic [PtrW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [PtrW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [CntW-1:0]      count_reg, count_next;

    // FIFO memory and prefetched head
    logic [LpdtByteW-1:0] fifo_mem [FIFO_DEPTH];
    logic [LpdtByteW-1:0] head_reg;
    logic                 wr_en;
    logic                 pop;

    // Output buffer
    lpdt_result_t out_reg, skid_reg, result;
    logic         out_valid_reg, skid_valid_reg;

    logic in_acc;
    logic out_take;
    logic is_push;
    logic fifo_empty;
    logic tx_bit;

    assign cfg_ready  = 1'b1;
    assign in_stall   = skid_valid_reg;
    assign in_acc     = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign is_push    = (operation == OP_PUSH);
    assign fifo_empty = (count_reg == '0);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_low_reg  <= LpdtBankLowReset;
            bank_mid_reg  <= LpdtBankMidReset;
            bank_high_reg <= LpdtBankHighReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BANK_LOW:  bank_low_reg  <= cfg_data;
                CFG_BANK_MID:  bank_mid_reg  <= cfg_data;
                CFG_BANK_HIGH: bank_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state of the phase machine and FIFO pointers
    always_comb
    begin
        phase_next  = phase_reg;
        shift_next  = shift_reg;
        bitptr_next = bitptr_reg;
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        pop         = 1'b0;
        tx_bit      = 1'b0;
        if (in_acc)
        begin
            if (is_push)
            begin
                if (count_reg != CntFull)
                begin
                    wr_en       = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
                    count_next  = count_reg + 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (!fifo_empty)
                        begin
                            pop         = 1'b1;
                            shift_next  = head_reg;
                            bitptr_next = LpdtBitStart;
                            phase_next  = PH_ON;
                        end
                    end
                    PH_ON:
                    begin
                        phase_next = PH_OFF;
                    end
                    PH_OFF:
                    begin
                        if (bitptr_reg[3] && fifo_empty)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            if (bitptr_reg[3])
                            begin
                                // closing pulse doubles as start of next byte
                                pop         = 1'b1;
                                shift_next  = head_reg;
                                tx_bit      = head_reg[LpdtByteW-1];
                                bitptr_next = LpdtBitStart - 4'd1;
                            end
                            else
                            begin
                                tx_bit      = shift_reg[bitptr_reg[2:0]];
                                bitptr_next = bitptr_reg - 4'd1;
                            end
                            phase_next = tx_bit ? PH_ON : PH_LOW;
                        end
                    end
                    PH_LOW:
                    begin
                        phase_next = PH_ON;
                    end
                    default: ;
                endcase
            end
            if (pop)
            begin
                rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
                count_next  = count_reg - 1'b1;
            end
        end
    end

    // Result fields of the current request
    always_comb
    begin
        result          = '0;
        result.tx_phase = phase_next;
        if (is_push)
        begin
            result.byte_dropped = (count_reg == CntFull);
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    result.receiver_enable_written = 1'b1;
                    result.receiver_enable_value   = fifo_empty;
                    result.receiver_reset_pulse    = !fifo_empty;
                end
                PH_ON:
                begin
                    result.leds_written  = 1'b1;
                    result.bank_low_out  = bank_low_reg;
                    result.bank_mid_out  = bank_mid_reg;
                    result.bank_high_out = bank_high_reg;
                end
                PH_OFF:
                begin
                    result.leds_written = 1'b1;
                end
                PH_LOW: ;
                default: ;
            endcase
        end
    end

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            shift_reg  <= '0;
            bitptr_reg <= LpdtBitStart;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            shift_reg  <= shift_next;
            bitptr_reg <= bitptr_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // FIFO memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fifo_mem[wr_ptr_reg] <= data_byte;
        end
    end

    // Head prefetch at the next read pointer, forwarding a same-entry write
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= data_byte;
        end
        else
        begin
            head_reg <= fifo_mem[rd_ptr_next];
        end
    end

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_acc)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_acc)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign out_valid               = out_valid_reg;
    assign leds_written            = out_reg.leds_written;
    assign bank_low_out            = out_reg.bank_low_out;
    assign bank_mid_out            = out_reg.bank_mid_out;
    assign bank_high_out           = out_reg.bank_high_out;
    assign receiver_enable_written = out_reg.receiver_enable_written;
    assign receiver_enable_value   = out_reg.receiver_enable_value;
    assign receiver_reset_pulse    = out_reg.receiver_reset_pulse;
    assign byte_dropped            = out_reg.byte_dropped;
    assign tx_phase                = out_reg.tx_phase;

endmodule

FILE: bench/lpdt_checker.sv
// Result checker for the LED pulse-distance transmitter: watches the request,
// configuration and result channels, predicts each result and compares it.
// Depends on lpdt_pkg for the operation, phase, register and result types.
module lpdt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                operation,
    input  logic [lpdt_pkg::LpdtByteW-1:0]      data_byte,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [lpdt_pkg::LpdtCfgIdxW-1:0]    cfg_index,
    input  logic [lpdt_pkg::LpdtByteW-1:0]      cfg_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                leds_written,
    input  logic [lpdt_pkg::LpdtByteW-1:0]      bank_low_out,
    input  logic [lpdt_pkg::LpdtByteW-1:0]      bank_mid_out,
    input  logic [lpdt_pkg::LpdtByteW-1:0]      bank_high_out,
    input  logic                                receiver_enable_written,
    input  logic                                receiver_enable_value,
    input  logic                                receiver_reset_pulse,
    input  logic                                byte_dropped,
    input  logic [1:0]                          tx_phase,
    output int                                  failures,
    output int                                  pending
);
    import lpdt_pkg::*;

    // Shadow copy of the transmitter state and the bank patterns
    lpdt_phase_t          tx_state;
    logic [LpdtByteW-1:0] tx_shift;
    logic [3:0]           tx_bit;
    logic [LpdtByteW-1:0] fifo_mem [0:LpdtFifoDepth-1];
    int                   fifo_rd;
    int                   fifo_wr;
    int                   fifo_fill;
    logic [LpdtByteW-1:0] pattern_low;
    logic [LpdtByteW-1:0] pattern_mid;
    logic [LpdtByteW-1:0] pattern_high;

    lpdt_result_t         led_result_q [$];
    lpdt_result_t         want;

    // Take the FIFO head into the shift register, MSB first
    function automatic void load_next_byte();
        tx_shift  = fifo_mem[fifo_rd];
        fifo_rd   = (fifo_rd + 1) % LpdtFifoDepth;
        fifo_fill = fifo_fill - 1;
        tx_bit    = LpdtBitStart;
    endfunction

    // Expected result of one request; advances the shadow state
    function automatic lpdt_result_t next_led_result(lpdt_op_t op,
                                                     logic [LpdtByteW-1:0] byte_in);
        lpdt_result_t res;
        res = '0;
        if (op == OP_PUSH) begin
            if (fifo_fill >= LpdtFifoDepth) begin
                res.byte_dropped = 1'b1;
            end else begin
                fifo_mem[fifo_wr] = byte_in;
                fifo_wr   = (fifo_wr + 1) % LpdtFifoDepth;
                fifo_fill = fifo_fill + 1;
            end
        end else begin
            case (tx_state)
                PH_IDLE: begin
                    res.receiver_enable_written = 1'b1;
                    if (fifo_fill == 0) begin
                        res.receiver_enable_value = 1'b1;
                    end else begin
                        load_next_byte();
                        res.receiver_reset_pulse = 1'b1;
                        tx_state = PH_ON;
                    end
                end
                PH_ON: begin
                    res.leds_written  = 1'b1;
                    res.bank_low_out  = pattern_low;
                    res.bank_mid_out  = pattern_mid;
                    res.bank_high_out = pattern_high;
                    tx_state = PH_OFF;
                end
                PH_OFF: begin
                    // LEDs driven off; byte done and nothing queued ends the frame
                    res.leds_written = 1'b1;
                    if (tx_bit[3] && fifo_fill == 0) begin
                        tx_state = PH_IDLE;
                    end else begin
                        if (tx_bit[3])
                            load_next_byte();
                        tx_state = tx_shift[tx_bit[2:0]] ? PH_ON : PH_LOW;
                        tx_bit   = tx_bit - 4'd1;
                    end
                end
                PH_LOW: begin
                    tx_state = PH_ON;
                end
            endcase
        end
        res.tx_phase = tx_state;
        return res;
    endfunction

    task automatic compare_field(string name, logic [LpdtByteW-1:0] exp_v,
                                 logic [LpdtByteW-1:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tx_state     = PH_IDLE;
            tx_shift     = '0;
            tx_bit       = LpdtBitStart;
            fifo_rd      = 0;
            fifo_wr      = 0;
            fifo_fill    = 0;
            pattern_low  = LpdtBankLowReset;
            pattern_mid  = LpdtBankMidReset;
            pattern_high = LpdtBankHighReset;
            led_result_q.delete();
            failures     = 0;
            pending      = 0;
        end else begin
            // result side: compare against the oldest prediction
            if (out_valid && !out_stall) begin
                if (led_result_q.size() == 0) begin
                    $error("result seen with no request outstanding");
                    failures++;
                end else begin
                    want = led_result_q.pop_front();
                    compare_field("leds_written", LpdtByteW'(want.leds_written),
                                  LpdtByteW'(leds_written));
                    compare_field("bank_low_out", want.bank_low_out, bank_low_out);
                    compare_field("bank_mid_out", want.bank_mid_out, bank_mid_out);
                    compare_field("bank_high_out", want.bank_high_out, bank_high_out);
                    compare_field("receiver_enable_written",
                                  LpdtByteW'(want.receiver_enable_written),
                                  LpdtByteW'(receiver_enable_written));
                    compare_field("receiver_enable_value",
                                  LpdtByteW'(want.receiver_enable_value),
                                  LpdtByteW'(receiver_enable_value));
                    compare_field("receiver_reset_pulse",
                                  LpdtByteW'(want.receiver_reset_pulse),
                                  LpdtByteW'(receiver_reset_pulse));
                    compare_field("byte_dropped", LpdtByteW'(want.byte_dropped),
                                  LpdtByteW'(byte_dropped));
                    compare_field("tx_phase", LpdtByteW'(want.tx_phase),
                                  LpdtByteW'(tx_phase));
                end
            end
            // request side, seeing the patterns held before this edge
            if (in_valid && !in_stall)
                led_result_q.push_back(next_led_result(lpdt_op_t'(operation), data_byte));
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (lpdt_cfg_idx_t'(cfg_index))
                    CFG_BANK_LOW:  pattern_low  = cfg_data;
                    CFG_BANK_MID:  pattern_mid  = cfg_data;
                    CFG_BANK_HIGH: pattern_high = cfg_data;
                    default: ;
                endcase
            end
            pending = led_result_q.size();
        end
    end

endmodule

FILE: bench/tb_led_pulse_distance_transmitter.sv
// Testbench top for the LED pulse-distance transmitter: clock, reset, request
// and register stimulus, result-side stalls and the final verdict.
// Depends on lpdt_pkg, led_pulse_distance_transmitter and lpdt_checker.
module tb_led_pulse_distance_transmitter;
    import lpdt_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   operation;
    logic [LpdtByteW-1:0]   data_byte;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [LpdtCfgIdxW-1:0] cfg_index;
    logic [LpdtByteW-1:0]   cfg_data;
    logic                   out_valid;
    logic                   out_stall;
    logic                   leds_written;
    logic [LpdtByteW-1:0]   bank_low_out;
    logic [LpdtByteW-1:0]   bank_mid_out;
    logic [LpdtByteW-1:0]   bank_high_out;
    logic                   receiver_enable_written;
    logic                   receiver_enable_value;
    logic                   receiver_reset_pulse;
    logic                   byte_dropped;
    logic [1:0]             tx_phase;

    int   failures;
    int   pending;
    int   burst_left;
    logic hold_req;
    logic hold_used;

    led_pulse_distance_transmitter dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_stall                (in_stall),
        .operation               (operation),
        .data_byte               (data_byte),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .out_valid               (out_valid),
        .out_stall               (out_stall),
        .leds_written            (leds_written),
        .bank_low_out            (bank_low_out),
        .bank_mid_out            (bank_mid_out),
        .bank_high_out           (bank_high_out),
        .receiver_enable_written (receiver_enable_written),
        .receiver_enable_value   (receiver_enable_value),
        .receiver_reset_pulse    (receiver_reset_pulse),
        .byte_dropped            (byte_dropped),
        .tx_phase                (tx_phase)
    );

    lpdt_checker result_checker (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .in_valid                (in_valid),
        .in_stall                (in_stall),
        .operation               (operation),
        .data_byte               (data_byte),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .out_valid               (out_valid),
        .out_stall               (out_stall),
        .leds_written            (leds_written),
        .bank_low_out            (bank_low_out),
        .bank_mid_out            (bank_mid_out),
        .bank_high_out           (bank_high_out),
        .receiver_enable_written (receiver_enable_written),
        .receiver_enable_value   (receiver_enable_value),
        .receiver_reset_pulse    (receiver_reset_pulse),
        .byte_dropped            (byte_dropped),
        .tx_phase                (tx_phase),
        .failures                (failures),
        .pending                 (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result-side stalls: segments of differing behaviour, plus one long hold
    initial
    begin
        int seg_len;
        int mode;
        int tick_cnt;
        out_stall = 1'b0;
        hold_used = 1'b0;
        tick_cnt  = 0;
        @(posedge rst_n);
        forever
        begin
            seg_len = $urandom_range(20, 200);
            mode    = $urandom_range(0, 3);
            repeat (seg_len)
            begin
                @(posedge clk);
                tick_cnt++;
                if (hold_req && !hold_used)
                begin
                    hold_used = 1'b1;
                    repeat (150)
                    begin
                        out_stall <= 1'b1;
                        @(posedge clk);
                    end
                end
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < 30);
                    2: out_stall <= ($urandom_range(0, 99) < 75);
                    default: out_stall <= (tick_cnt % 5 == 0);
                endcase
            end
        end
    end

    // Offer one request; bursts of random length separated by random gaps
    task automatic send_request(lpdt_op_t op, logic [LpdtByteW-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        operation <= op;
        data_byte <= value;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_bank(lpdt_cfg_idx_t idx, logic [LpdtByteW-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every outstanding request has produced its result
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending != 0 && waited < 20000);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed frames: a few pushes then enough ticks to send them
    task automatic run_traffic(int target);
        int sent;
        int pick;
        int pushes;
        int ticks;
        sent = 0;
        while (sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 88)
            begin
                pushes = $urandom_range(0, 3);
                ticks  = pushes * 27 + $urandom_range(3, 10);
            end
            else if (pick < 92)
            begin
                // overfill the FIFO, then send only part of it
                pushes = $urandom_range(17, 20);
                ticks  = $urandom_range(0, 200);
            end
            else
            begin
                pushes = 0;
                ticks  = 0;
                repeat ($urandom_range(1, 20))
                begin
                    send_request(lpdt_op_t'($urandom_range(0, 1)),
                                 LpdtByteW'($urandom_range(0, 255)));
                    sent++;
                end
            end
            repeat (pushes)
            begin
                send_request(OP_PUSH, LpdtByteW'($urandom_range(0, 255)));
                sent++;
            end
            repeat (ticks)
            begin
                if ($urandom_range(0, 99) < 5)
                begin
                    send_request(OP_PUSH, LpdtByteW'($urandom_range(0, 255)));
                    sent++;
                end
                send_request(OP_TICK, '0);
                sent++;
            end
        end
    endtask

    // Main stimulus
    initial
    begin
        logic [LpdtByteW-1:0] lo_v;
        logic [LpdtByteW-1:0] mid_v;
        logic [LpdtByteW-1:0] hi_v;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_TICK;
        data_byte  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_BANK_LOW;
        cfg_data   = '0;
        hold_req   = 1'b0;
        burst_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, fill the FIFO to overflow, start sending
        send_request(OP_TICK, '0);
        send_request(OP_PUSH, 8'hFF);
        send_request(OP_PUSH, 8'h00);
        send_request(OP_PUSH, 8'h80);
        send_request(OP_PUSH, 8'h01);
        for (int i = 0; i < 12; i++)
            send_request(OP_PUSH, LpdtByteW'(8'h5A ^ (i * 8'h13)));
        send_request(OP_PUSH, 8'hAA);
        send_request(OP_TICK, '0);
        send_request(OP_TICK, '0);
        send_request(OP_TICK, '0);
        send_request(OP_TICK, '0);
        send_request(OP_PUSH, 8'h55);

        // Random phases, each under its own bank patterns
        for (int p = 0; p < 4; p++)
        begin
            drain();
            case (p)
                0: begin lo_v = 8'hFF; mid_v = 8'hFF; hi_v = 8'hFF; end
                1: begin lo_v = 8'h00; mid_v = 8'h00; hi_v = 8'h00; end
                default:
                begin
                    lo_v  = LpdtByteW'($urandom_range(0, 255));
                    mid_v = LpdtByteW'($urandom_range(0, 255));
                    hi_v  = LpdtByteW'($urandom_range(0, 255));
                end
            endcase
            write_bank(CFG_BANK_HIGH, hi_v);
            write_bank(CFG_BANK_LOW, lo_v);
            write_bank(CFG_BANK_MID, mid_v);
            if (p == 1)
            begin
                // long receiver hold with the sender kept busy
                hold_req   <= 1'b1;
                burst_left = 40;
                repeat (30)
                    send_request(lpdt_op_t'($urandom_range(0, 1)),
                                 LpdtByteW'($urandom_range(0, 255)));
                hold_req <= 1'b0;
            end
            run_traffic(470);
        end

        drain();
        repeat (10) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
